@@ src/wpe_pkg.sv @@
package wpe_pkg;

  localparam int COORD_W    = 24;
  localparam int INDEX_W    = 9;
  localparam int ENERGY_W   = 32;
  localparam int W_W        = 31;
  localparam int Q_W        = 48;
  localparam int Q_STEPS    = 4;
  localparam int DIV_W      = 48;
  localparam int DIV_ITERS  = DIV_W / Q_STEPS;
  localparam int FOLD_STEPS = 4;
  localparam int FOLD_ITERS = COORD_W / FOLD_STEPS;
  localparam int FOLD_LAT   = FOLD_ITERS + 2;

  localparam logic [W_W-1:0] CUTOFF_Q30 = 31'd1352829926;
  localparam logic [Q_W-1:0] ONE_Q16    = 48'd65536;
  localparam logic [Q_W-1:0] T_LIMIT    = 48'd16777216;
  localparam logic [DIV_W-1:0] DIVIDEND = 48'h8000_0000_0000;

  localparam logic [1:0] REG_BOX_X = 2'd0;
  localparam logic [1:0] REG_BOX_Y = 2'd1;
  localparam logic [1:0] REG_BOX_Z = 2'd2;

  // one pipeline stage of the restoring divider
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] dvs;
  } div_t;

  // one pipeline stage of the periodic fold remainder
  typedef struct packed {
    logic [COORD_W-1:0] rem;
    logic [COORD_W-1:0] num;
    logic [COORD_W-1:0] len;
  } fold_t;

  // flags carried alongside the data
  typedef struct packed {
    logic zero;
    logic hit;
    logic sat;
  } flag_t;

endpackage

@@ src/wca_pair_energy.sv @@
// throughput: one pair per cycle unless the output side stalls; stages are an 8-stage
//   fold (magnitude, six radix-16 remainder steps, nearest image), squares, sum and
//   cutoff, w^2, w^3, a 12-stage radix-16 divider for 2^47 / w3, t and saturation,
//   and the final square
// reset: rst synchronous, clears all valid bits and sets each box length to 16.0
// a stall on the output side freezes the whole pipeline
module wca_pair_energy (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  // focus_index, other_index, focus_x, focus_y, focus_z, other_x, other_y, other_z, pad
  input  logic [167:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pair_energy, within_cutoff, saturated, pad
  output logic [39:0] m_tdata
);

  localparam int NST = wpe_pkg::FOLD_LAT + wpe_pkg::DIV_ITERS + 6;

  logic [wpe_pkg::COORD_W-1:0] box_x, box_y, box_z;
  logic en;
  logic [NST-1:0] vld;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      box_x <= 24'd1048576;
      box_y <= 24'd1048576;
      box_z <= 24'd1048576;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        wpe_pkg::REG_BOX_X: box_x <= pwdata[23:0];
        wpe_pkg::REG_BOX_Y: box_y <= pwdata[23:0];
        wpe_pkg::REG_BOX_Z: box_z <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      wpe_pkg::REG_BOX_X: prdata = {8'd0, box_x};
      wpe_pkg::REG_BOX_Y: prdata = {8'd0, box_y};
      wpe_pkg::REG_BOX_Z: prdata = {8'd0, box_z};
      default:            prdata = '0;
    endcase
  end

  // pipeline advances unless the result is held
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[NST-2:0], s_tvalid};
  end
  assign m_tvalid = vld[NST-1];

  // folding stages
  logic [23:0] dx, dy, dz;
  wpe_fold u_fx (.clk, .en, .p(s_tdata[41:18]),  .q(s_tdata[113:90]),  .len(box_x), .d(dx));
  wpe_fold u_fy (.clk, .en, .p(s_tdata[65:42]),  .q(s_tdata[137:114]), .len(box_y), .d(dy));
  wpe_fold u_fz (.clk, .en, .p(s_tdata[89:66]),  .q(s_tdata[161:138]), .len(box_z), .d(dz));

  logic [wpe_pkg::FOLD_LAT-1:0] zero_p;
  always_ff @(posedge clk) begin
    if (en) zero_p <= {zero_p[wpe_pkg::FOLD_LAT-2:0], s_tdata[8:0] == s_tdata[17:9]};
  end

  // squares
  logic [47:0] sx, sy, sz;
  logic        z3;
  always_ff @(posedge clk) begin
    if (en) begin
      sx <= dx * dx;
      sy <= dy * dy;
      sz <= dz * dz;
      z3 <= zero_p[wpe_pkg::FOLD_LAT-1];
    end
  end

  // sum, range and cutoff test
  logic [49:0] r2;
  logic [30:0] w;
  logic        hit4;
  assign r2 = {2'b0, sx} + {2'b0, sy} + {2'b0, sz};
  always_ff @(posedge clk) begin
    if (en) begin
      w    <= r2[32:2];
      hit4 <= !z3 && (r2[49:33] == '0) && (r2[32:2] <= wpe_pkg::CUTOFF_Q30);
    end
  end

  // w^2
  logic [61:0] ww;
  logic [30:0] w5;
  logic        hit5;
  always_ff @(posedge clk) begin
    if (en) begin
      ww   <= w * w;
      w5   <= w;
      hit5 <= hit4;
    end
  end

  // w^3
  logic [61:0] www;
  logic        hit6;
  always_ff @(posedge clk) begin
    if (en) begin
      www  <= ww[61:30] * w5;
      hit6 <= hit5;
    end
  end

  // divider stages, four quotient bits each
  wpe_pkg::div_t dv [wpe_pkg::DIV_ITERS+1];
  logic [wpe_pkg::DIV_ITERS:0] hitd;
  logic [wpe_pkg::DIV_ITERS:0] zd;
  assign dv[0].rem = '0;
  assign dv[0].quo = wpe_pkg::DIVIDEND;
  assign dv[0].dvs = {17'd0, www[60:30]};
  assign hitd[0]   = hit6;
  assign zd[0]     = (www[61:30] == '0);

  for (genvar g = 0; g < wpe_pkg::DIV_ITERS; g++) begin : g_div
    wpe_pkg::div_t nx;
    always_comb begin
      nx = dv[g];
      for (int b = 0; b < wpe_pkg::Q_STEPS; b++) begin
        nx.rem = {nx.rem[wpe_pkg::DIV_W-2:0], nx.quo[wpe_pkg::DIV_W-1]};
        nx.quo = {nx.quo[wpe_pkg::DIV_W-2:0], 1'b0};
        if (nx.rem >= nx.dvs) begin
          nx.rem    = nx.rem - nx.dvs;
          nx.quo[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[g+1]   <= nx;
        hitd[g+1] <= hitd[g];
        zd[g+1]   <= zd[g];
      end
    end
  end

  // stage: t and saturation
  logic [47:0] q, t;
  logic [23:0] t_r;
  wpe_pkg::flag_t fl;
  assign q = dv[wpe_pkg::DIV_ITERS].quo;
  assign t = (q > wpe_pkg::ONE_Q16) ? (q - wpe_pkg::ONE_Q16) : '0;
  always_ff @(posedge clk) begin
    if (en) begin
      t_r     <= t[23:0];
      fl.hit  <= hitd[wpe_pkg::DIV_ITERS];
      fl.zero <= zd[wpe_pkg::DIV_ITERS];
      fl.sat  <= zd[wpe_pkg::DIV_ITERS] || (t >= wpe_pkg::T_LIMIT);
    end
  end

  // final square and output register
  logic [47:0] tt;
  logic        o_hit, o_sat;
  logic [31:0] o_e;
  assign tt = t_r * t_r;
  always_ff @(posedge clk) begin
    if (en) begin
      o_hit <= fl.hit;
      o_sat <= fl.hit && fl.sat;
      o_e   <= !fl.hit ? 32'd0 : (fl.sat ? 32'hFFFF_FFFF : tt[47:16]);
    end
  end
  assign m_tdata = {6'd0, o_sat, o_hit, o_e};

  // saturation only inside the cutoff
  a_sat_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[33] || m_tdata[32])) else $error("saturated outside cutoff");
  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed under stall");
  // no request taken while stalled
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready) else $error("input taken during stall");

endmodule

@@ src/wpe_fold.sv @@
module wpe_fold (
  input  logic                        clk,
  input  logic                        en,
  input  logic [wpe_pkg::COORD_W-1:0] p,
  input  logic [wpe_pkg::COORD_W-1:0] q,
  input  logic [wpe_pkg::COORD_W-1:0] len,
  output logic [wpe_pkg::COORD_W-1:0] d
);

  logic [wpe_pkg::COORD_W-1:0] a;
  wpe_pkg::fold_t              fs [wpe_pkg::FOLD_ITERS+1];
  logic [wpe_pkg::COORD_W-1:0] m;
  logic [wpe_pkg::COORD_W-1:0] len_f;
  logic [wpe_pkg::COORD_W-1:0] lm;

  // magnitude of the displacement
  assign a = (p > q) ? (p - q) : (q - p);

  always_ff @(posedge clk) begin
    if (en) begin
      fs[0].rem <= '0;
      fs[0].num <= a;
      fs[0].len <= len;
    end
  end

  // a mod len, four remainder bits per stage; a zero length leaves a unchanged
  for (genvar g = 0; g < wpe_pkg::FOLD_ITERS; g++) begin : g_mod
    wpe_pkg::fold_t            nx;
    logic [wpe_pkg::COORD_W:0] sh;
    always_comb begin
      nx = fs[g];
      sh = '0;
      for (int b = 0; b < wpe_pkg::FOLD_STEPS; b++) begin
        sh     = {nx.rem, nx.num[wpe_pkg::COORD_W-1]};
        nx.num = {nx.num[wpe_pkg::COORD_W-2:0], 1'b0};
        if (sh >= {1'b0, nx.len}) sh = sh - {1'b0, nx.len};
        nx.rem = sh[wpe_pkg::COORD_W-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en) fs[g+1] <= nx;
    end
  end

  // nearest image from the remainder
  assign m     = fs[wpe_pkg::FOLD_ITERS].rem;
  assign len_f = fs[wpe_pkg::FOLD_ITERS].len;
  assign lm    = len_f - m;

  always_ff @(posedge clk) begin
    if (en) begin
      d <= (len_f == '0) ? m : ((m <= lm) ? m : lm);
    end
  end

endmodule
